// ----- rtl/lmwf_pkg.sv -----
// Package for the letter multiset word filter.
// Holds the item types, opcodes, character constants and character helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lmwf_pkg;

    localparam int ALPHABET_LETTERS   = 26;
    localparam int MAX_LENGTH_DEFAULT = 255;
    localparam int LETTER_IDX_W       = $clog2(ALPHABET_LETTERS);
    localparam int MATCH_W            = 16;
    localparam int REPORT_LEN_W       = 8;

    // byte address of the anagram_mode register
    localparam logic [1:0] ADDR_ANAGRAM_MODE = 2'd0;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_REF_CHAR = 2'd1,
        OP_DICT_CHR = 2'd2,
        OP_EOL      = 2'd3
    } op_t;

    typedef struct packed {
        op_t        opcode;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic                    matched;
        logic [REPORT_LEN_W-1:0] word_length;
        logic [MATCH_W-1:0]      match_total;
    } out_item_t;

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z], [CHAR_LOWER_A:CHAR_LOWER_Z]});
    endfunction

    function automatic logic [LETTER_IDX_W-1:0] letter_idx(input logic [7:0] c);
        logic [7:0] off;
        off = (c <= CHAR_UPPER_Z) ? (c - CHAR_UPPER_A) : (c - CHAR_LOWER_A);
        letter_idx = off[LETTER_IDX_W-1:0];
    endfunction

    function automatic logic ends_word(input logic [7:0] c);
        ends_word = (c == CHAR_NUL) || (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lmwf_core.sv -----
// Filter state and per-item update: reference and word letter histograms.
// Depends on lmwf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmwf_core #(
    parameter int MAX_LENGTH = lmwf_pkg::MAX_LENGTH_DEFAULT
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  step,
    input  lmwf_pkg::in_item_t   item,
    input  wire                  anagram_mode,
    output lmwf_pkg::out_item_t  result,
    output logic                 result_valid
);

    localparam int CW = $clog2(MAX_LENGTH + 1);
    localparam int WW = (CW > lmwf_pkg::REPORT_LEN_W) ? CW : lmwf_pkg::REPORT_LEN_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LENGTH);
    localparam logic [lmwf_pkg::MATCH_W-1:0] MATCH_MAX = '1;
    localparam logic [lmwf_pkg::MATCH_W-1:0] MATCH_ONE = {{(lmwf_pkg::MATCH_W-1){1'b0}}, 1'b1};

    logic [CW-1:0] ref_cnt_reg  [lmwf_pkg::ALPHABET_LETTERS];
    logic [CW-1:0] ref_cnt_next [lmwf_pkg::ALPHABET_LETTERS];
    logic [CW-1:0] wrd_cnt_reg  [lmwf_pkg::ALPHABET_LETTERS];
    logic [CW-1:0] wrd_cnt_next [lmwf_pkg::ALPHABET_LETTERS];
    logic [CW-1:0] ref_len_reg, ref_len_next;
    logic [CW-1:0] ref_tot_reg, ref_tot_next;
    logic [CW-1:0] wrd_len_reg, wrd_len_next;
    logic [CW-1:0] wrd_tot_reg, wrd_tot_next;
    logic          failed_reg, failed_next;
    logic          past_end_reg, past_end_next;
    logic [lmwf_pkg::MATCH_W-1:0] match_reg, match_next;

    logic                              letter;
    logic [lmwf_pkg::LETTER_IDX_W-1:0] idx;
    logic [CW-1:0]                     cnt_inc;
    logic                              ok;
    logic [WW-1:0]                     len_ext;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        sat_inc = (v >= CNT_MAX) ? CNT_MAX : v + CW'(1);
    endfunction

    assign letter  = lmwf_pkg::is_letter(item.char_code);
    assign idx     = lmwf_pkg::letter_idx(item.char_code);
    assign len_ext = WW'(wrd_len_reg);

    always_comb
    begin
        ref_cnt_next  = ref_cnt_reg;
        wrd_cnt_next  = wrd_cnt_reg;
        ref_len_next  = ref_len_reg;
        ref_tot_next  = ref_tot_reg;
        wrd_len_next  = wrd_len_reg;
        wrd_tot_next  = wrd_tot_reg;
        failed_next   = failed_reg;
        past_end_next = past_end_reg;
        match_next    = match_reg;
        cnt_inc       = sat_inc(wrd_cnt_reg[idx]);
        ok            = !failed_reg && (wrd_len_reg != '0) && (wrd_len_reg <= ref_len_reg)
                        && (!anagram_mode || (wrd_tot_reg == ref_tot_reg));
        result_valid  = 1'b0;

        result.matched     = ok;
        result.word_length = (len_ext > WW'(255)) ? 8'hFF : len_ext[7:0];
        result.match_total = (ok && match_reg != MATCH_MAX) ? match_reg + MATCH_ONE : match_reg;

        case (item.opcode)
            lmwf_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < lmwf_pkg::ALPHABET_LETTERS; i++)
                begin
                    ref_cnt_next[i] = '0;
                    wrd_cnt_next[i] = '0;
                end
                ref_len_next  = '0;
                ref_tot_next  = '0;
                wrd_len_next  = '0;
                wrd_tot_next  = '0;
                failed_next   = 1'b0;
                past_end_next = 1'b0;
                match_next    = '0;
            end
            lmwf_pkg::OP_REF_CHAR:
            begin
                // a zero byte adds nothing to the reference
                if (item.char_code != lmwf_pkg::CHAR_NUL)
                begin
                    ref_len_next = sat_inc(ref_len_reg);
                    if (letter)
                    begin
                        ref_cnt_next[idx] = sat_inc(ref_cnt_reg[idx]);
                        ref_tot_next      = sat_inc(ref_tot_reg);
                    end
                end
            end
            lmwf_pkg::OP_DICT_CHR:
            begin
                if (!past_end_reg)
                begin
                    if (lmwf_pkg::ends_word(item.char_code))
                    begin
                        past_end_next = 1'b1;
                    end
                    else
                    begin
                        wrd_len_next = sat_inc(wrd_len_reg);
                        if (letter && !failed_reg)
                        begin
                            wrd_cnt_next[idx] = cnt_inc;
                            wrd_tot_next      = sat_inc(wrd_tot_reg);
                            if (cnt_inc > ref_cnt_reg[idx])
                                failed_next = 1'b1;
                        end
                    end
                end
            end
            lmwf_pkg::OP_EOL:
            begin
                result_valid = 1'b1;
                match_next   = result.match_total;
                for (int i = 0; i < lmwf_pkg::ALPHABET_LETTERS; i++)
                    wrd_cnt_next[i] = '0;
                wrd_len_next  = '0;
                wrd_tot_next  = '0;
                failed_next   = 1'b0;
                past_end_next = 1'b0;
            end
            default:
            begin
                result_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lmwf_pkg::ALPHABET_LETTERS; i++)
            begin
                ref_cnt_reg[i] <= '0;
                wrd_cnt_reg[i] <= '0;
            end
            ref_len_reg  <= '0;
            ref_tot_reg  <= '0;
            wrd_len_reg  <= '0;
            wrd_tot_reg  <= '0;
            failed_reg   <= 1'b0;
            past_end_reg <= 1'b0;
            match_reg    <= '0;
        end
        else if (step)
        begin
            ref_cnt_reg  <= ref_cnt_next;
            wrd_cnt_reg  <= wrd_cnt_next;
            ref_len_reg  <= ref_len_next;
            ref_tot_reg  <= ref_tot_next;
            wrd_len_reg  <= wrd_len_next;
            wrd_tot_reg  <= wrd_tot_next;
            failed_reg   <= failed_next;
            past_end_reg <= past_end_next;
            match_reg    <= match_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/letter_multiset_word_filter.sv -----
// An end-of-line item passes through the input register, then the result register, before out_valid rises.
// Throughput: one item per cycle; the input register and the result register
// decouple the two channels, so input stalls only when a result waits untaken and
// the item held in the input register is another end of line.
// Reset: rst_n (async, active low) clears all counts, the match counter and anagram_mode.
// Top level of the letter multiset word filter. Depends on lmwf_pkg and lmwf_core.
`timescale 1ns / 1ps
`default_nettype none

module letter_multiset_word_filter #(
    parameter int MAX_LENGTH = lmwf_pkg::MAX_LENGTH_DEFAULT
) (
    input  wire                  clk,
    input  wire                  rst_n,
    // input items
    input  wire                  in_valid,
    output logic                 in_ready,
    input  lmwf_pkg::in_item_t   in_data,
    // result items
    output logic                 out_valid,
    input  wire                  out_ready,
    output lmwf_pkg::out_item_t  out_data,
    // configuration
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [1:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    lmwf_pkg::in_item_t  in_reg;
    logic                in_valid_reg;
    lmwf_pkg::out_item_t out_reg;
    logic                out_valid_reg;
    logic                anagram_reg;

    lmwf_pkg::out_item_t core_result;
    logic                core_result_valid;
    logic                advance;

    // Single register at address zero; reads always return it.
    assign pready = 1'b1;
    assign prdata = {31'b0, anagram_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            anagram_reg <= 1'b0;
        else if (psel && penable && pwrite && (paddr == lmwf_pkg::ADDR_ANAGRAM_MODE))
            anagram_reg <= pwdata[0];
    end

    // Process the held item unless it makes a result and the result
    // register is still full and not being taken.
    assign advance  = in_valid_reg && (!core_result_valid || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_reg <= in_data;
    end

    lmwf_core #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (in_reg),
        .anagram_mode (anagram_reg),
        .result       (core_result),
        .result_valid (core_result_valid)
    );

    // Result register: load on a finished line, drop when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && core_result_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_result_valid)
            out_reg <= core_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
